[rtl/rsvm_pkg.sv]
// Shared types, codes and default sizes for the register stack machine.
package rsvm_pkg;

    localparam int STACK_DEPTH_DEF = 2048;
    localparam int CODE_LENGTH_DEF = 512;
    localparam int MAX_LEVELS_DEF  = 3;
    localparam int NUM_REGS_DEF    = 8;

    localparam int PC_OUT_W = 10;

    // I/O selectors of the SIO instruction.
    localparam int SIO_WRITE = 1;
    localparam int SIO_READ  = 2;
    localparam int SIO_HALT  = 3;

    typedef enum logic [4:0] {
        OP_LIT = 5'd1,
        OP_RTN = 5'd2,
        OP_LOD = 5'd3,
        OP_STO = 5'd4,
        OP_CAL = 5'd5,
        OP_INC = 5'd6,
        OP_JMP = 5'd7,
        OP_JPC = 5'd8,
        OP_SIO = 5'd9,
        OP_NEG = 5'd10,
        OP_ADD = 5'd11,
        OP_SUB = 5'd12,
        OP_MUL = 5'd13,
        OP_DIV = 5'd14,
        OP_ODD = 5'd15,
        OP_MOD = 5'd16,
        OP_EQL = 5'd17,
        OP_NEQ = 5'd18,
        OP_LSS = 5'd19,
        OP_LEQ = 5'd20,
        OP_GTR = 5'd21,
        OP_GEQ = 5'd22
    } op_t;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_DIV   = 2'd1,
        FAULT_RANGE = 2'd2
    } fault_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_Y,
        ST_RD_Z,
        ST_DISPATCH,
        ST_WALK,
        ST_WALK_WAIT,
        ST_LOD_WAIT,
        ST_CAL_W0,
        ST_CAL_W1,
        ST_CAL_W2,
        ST_CAL_W3,
        ST_RTN_RD,
        ST_RTN_W0,
        ST_RTN_W1,
        ST_DIV,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       rd_y;
        logic       rd_z;
        logic       exec;
        logic       walk_init;
        logic       walk_issue;
        logic       walk_step;
        logic       fail_range;
        logic       lod_issue;
        logic       lod_write;
        logic       sto_write;
        logic       cal_wr;
        logic [1:0] cal_sel;
        logic       rtn_issue_a;
        logic       rtn_issue_b;
        logic       rtn_finish;
        logic       div_start;
        logic       div_finish;
        logic       clr_wr;
        logic       finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       clear_last;
        logic       running;
        logic [4:0] opcode;
        logic       walk_bad;
        logic       walk_zero;
        logic       link_ok;
        logic       addr_ok;
        logic       frame_ok;
        logic       ret_ok;
        logic       y_zero;
        logic       div_done;
        logic       slot_free;
    } sts_t;

endpackage

[rtl/rsvm_if.sv]
// Valid/ready channel interfaces for instruction requests and results.
interface rsvm_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         opcode;
    logic [2:0]         reg_index;
    logic [2:0]         level_or_reg;
    logic signed [31:0] modifier;
    logic signed [31:0] read_value;

    modport source (output valid, opcode, reg_index, level_or_reg, modifier, read_value,
                    input ready);
    modport sink   (input valid, opcode, reg_index, level_or_reg, modifier, read_value,
                    output ready);
endinterface

interface rsvm_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         next_pc;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               halted;
    logic [1:0]         fault;

    modport source (output valid, next_pc, out_valid, out_value, halted, fault,
                    input ready);
    modport sink   (input valid, next_pc, out_valid, out_value, halted, fault,
                    output ready);
endinterface

[rtl/rsvm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rsvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/rsvm_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rsvm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               done,
    output logic [31:0]        quotient,
    output logic [31:0]        remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        shifted   = {rem_reg, quo_reg[31]};
        diff      = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            quo_next  = dividend[31] ? 32'(-dividend) : 32'(dividend);
            dvs_next  = divisor[31] ? 32'(-divisor) : 32'(divisor);
            rem_next  = '0;
            negq_next = dividend[31] ^ divisor[31];
            negr_next = dividend[31];
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign done      = done_reg;
    assign quotient  = negq_reg ? 32'd0 - quo_reg : quo_reg;
    assign remainder = negr_reg ? 32'd0 - rem_reg : rem_reg;

endmodule

[rtl/rsvm_datapath.sv]
// Datapath: machine registers, register file, frame memory, divider and result register.
module rsvm_datapath import rsvm_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int CODE_LENGTH = CODE_LENGTH_DEF,
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
    parameter int NUM_REGS    = NUM_REGS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [4:0]         opcode,
    input  logic [2:0]         reg_index,
    input  logic [2:0]         level_or_reg,
    input  logic signed [31:0] modifier,
    input  logic signed [31:0] read_value,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [9:0]         next_pc,
    output logic               out_valid,
    output logic signed [31:0] out_value,
    output logic               halted,
    output logic [1:0]         fault
);

    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int PC_W = $clog2(CODE_LENGTH + 1);
    localparam int RI_W = $clog2(NUM_REGS);
    localparam logic [31:0]     SD32   = 32'(STACK_DEPTH);
    localparam logic [31:0]     CL32   = 32'(CODE_LENGTH);
    localparam logic [PC_W-1:0] CL_PC  = PC_W'(CODE_LENGTH);
    localparam logic [SA_W-1:0] CLR_LAST = SA_W'(STACK_DEPTH - 1);

    function automatic logic in_stack(input logic [31:0] a);
        return a < SD32;
    endfunction

    function automatic logic [PC_W-1:0] set_pc(input logic [31:0] t);
        return (t < CL32) ? PC_W'(t) : CL_PC;
    endfunction

    function automatic logic reg_ok(input logic [31:0] idx);
        return idx < 32'(NUM_REGS);
    endfunction

    logic [4:0]         op_reg, op_next;
    logic [2:0]         r_reg, r_next;
    logic [2:0]         l_reg, l_next;
    logic signed [31:0] m_reg, m_next;
    logic signed [31:0] rv_reg, rv_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [31:0]        bp_reg, bp_next;
    logic [31:0]        sp_reg, sp_next;
    logic               running_reg, running_next;
    logic [31:0]        cur_reg, cur_next;
    logic [2:0]         lvl_reg, lvl_next;
    logic [31:0]        tmp_reg, tmp_next;
    fault_t             fault_reg, fault_next;
    logic               emit_reg, emit_next;
    logic [31:0]        ov_reg, ov_next;
    logic [SA_W-1:0]    clr_reg, clr_next;
    logic               full_reg, full_next;
    logic [9:0]         opc_reg, opc_next;
    logic               oemit_reg, oemit_next;
    logic [31:0]        oval_reg, oval_next;
    logic               ohalt_reg, ohalt_next;
    fault_t             ofault_reg, ofault_next;

    logic [31:0] regs_reg [NUM_REGS];
    logic [31:0] rd_sel;
    logic [31:0] rd_val;
    logic        wr_en;
    logic [31:0] wr_data;

    logic            mem_we, mem_re;
    logic [31:0]     mem_wa, mem_ra;
    logic [31:0]     mem_wd, mem_rd;

    logic [31:0] link_addr, data_addr, ret_base, ret_a, ret_b;
    logic [31:0] fr1, fr2, fr3, fr4;
    logic        slot_free;

    logic        div_done;
    logic [31:0] div_q, div_r;

    // Single read port on the register file, shared by the accept, Y-read and Z-read steps.
    always_comb
    begin
        if (cmd.accept)
        begin
            rd_sel = {29'd0, level_or_reg};
        end
        else if (cmd.rd_y)
        begin
            rd_sel = m_reg;
        end
        else
        begin
            rd_sel = {29'd0, r_reg};
        end
        rd_val = reg_ok(rd_sel) ? regs_reg[rd_sel[RI_W-1:0]] : 32'd0;
    end

    assign link_addr = cur_reg + 32'd1;
    assign data_addr = cur_reg + m_reg;
    assign ret_base  = bp_reg - 32'd1;
    assign ret_a     = ret_base + 32'd3;
    assign ret_b     = ret_base + 32'd4;
    assign fr1       = sp_reg + 32'd1;
    assign fr2       = sp_reg + 32'd2;
    assign fr3       = sp_reg + 32'd3;
    assign fr4       = sp_reg + 32'd4;
    assign slot_free = !full_reg || res_ready;

    always_comb
    begin
        op_next      = op_reg;
        r_next       = r_reg;
        l_next       = l_reg;
        m_next       = m_reg;
        rv_next      = rv_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        pc_next      = pc_reg;
        bp_next      = bp_reg;
        sp_next      = sp_reg;
        running_next = running_reg;
        cur_next     = cur_reg;
        lvl_next     = lvl_reg;
        tmp_next     = tmp_reg;
        fault_next   = fault_reg;
        emit_next    = emit_reg;
        ov_next      = ov_reg;
        clr_next     = clr_reg;
        full_next    = full_reg;
        opc_next     = opc_reg;
        oemit_next   = oemit_reg;
        oval_next    = oval_reg;
        ohalt_next   = ohalt_reg;
        ofault_next  = ofault_reg;
        wr_en        = 1'b0;
        wr_data      = 32'd0;
        mem_we       = 1'b0;
        mem_wa       = 32'd0;
        mem_wd       = 32'd0;
        mem_re       = 1'b0;
        mem_ra       = 32'd0;

        if (full_reg && res_ready)
        begin
            full_next = 1'b0;
        end

        if (cmd.accept)
        begin
            op_next    = opcode;
            r_next     = reg_index;
            l_next     = level_or_reg;
            m_next     = modifier;
            rv_next    = read_value;
            x_next     = rd_val;
            fault_next = FAULT_NONE;
            emit_next  = 1'b0;
            ov_next    = 32'd0;
            if (running_reg)
            begin
                pc_next = pc_reg + PC_W'(1);
            end
        end

        if (cmd.rd_y)
        begin
            y_next = rd_val;
        end

        if (cmd.rd_z)
        begin
            z_next = rd_val;
        end

        if (cmd.exec)
        begin
            case (op_t'(op_reg))
                OP_LIT: begin wr_en = 1'b1; wr_data = m_reg; end
                OP_NEG: begin wr_en = 1'b1; wr_data = 32'd0 - x_reg; end
                OP_ADD: begin wr_en = 1'b1; wr_data = x_reg + y_reg; end
                OP_SUB: begin wr_en = 1'b1; wr_data = x_reg - y_reg; end
                OP_MUL: begin wr_en = 1'b1; wr_data = x_reg * y_reg; end
                OP_ODD: begin wr_en = 1'b1; wr_data = {31'd0, z_reg[0]}; end
                OP_EQL: begin wr_en = 1'b1; wr_data = {31'd0, x_reg == y_reg}; end
                OP_NEQ: begin wr_en = 1'b1; wr_data = {31'd0, x_reg != y_reg}; end
                OP_LSS: begin wr_en = 1'b1; wr_data = {31'd0, x_reg < y_reg}; end
                OP_LEQ: begin wr_en = 1'b1; wr_data = {31'd0, x_reg <= y_reg}; end
                OP_GTR: begin wr_en = 1'b1; wr_data = {31'd0, x_reg > y_reg}; end
                OP_GEQ: begin wr_en = 1'b1; wr_data = {31'd0, x_reg >= y_reg}; end
                OP_JMP: pc_next = set_pc(m_reg);
                OP_JPC:
                begin
                    if (z_reg == 32'sd0)
                    begin
                        pc_next = set_pc(m_reg);
                    end
                end
                OP_INC: sp_next = sp_reg + m_reg;
                OP_DIV, OP_MOD:
                begin
                    // Only reached with a zero divisor.
                    wr_en      = 1'b1;
                    wr_data    = 32'd0;
                    fault_next = FAULT_DIV;
                end
                OP_SIO:
                begin
                    if (m_reg == 32'(SIO_WRITE))
                    begin
                        emit_next = 1'b1;
                        ov_next   = z_reg;
                    end
                    else if (m_reg == 32'(SIO_READ))
                    begin
                        wr_en   = 1'b1;
                        wr_data = rv_reg;
                    end
                    else if (m_reg == 32'(SIO_HALT))
                    begin
                        running_next = 1'b0;
                        sp_next      = 32'd0;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.walk_init)
        begin
            cur_next = bp_reg;
            lvl_next = l_reg;
        end

        if (cmd.fail_range)
        begin
            fault_next = FAULT_RANGE;
        end

        if (cmd.walk_issue)
        begin
            mem_re = 1'b1;
            mem_ra = link_addr;
        end

        if (cmd.walk_step)
        begin
            cur_next = mem_rd;
            lvl_next = lvl_reg - 3'd1;
        end

        if (cmd.lod_issue)
        begin
            mem_re = 1'b1;
            mem_ra = data_addr;
        end

        if (cmd.lod_write)
        begin
            wr_en   = 1'b1;
            wr_data = mem_rd;
        end

        if (cmd.sto_write && reg_ok({29'd0, r_reg}))
        begin
            mem_we = 1'b1;
            mem_wa = data_addr;
            mem_wd = z_reg;
        end

        if (cmd.cal_wr)
        begin
            mem_we = 1'b1;
            unique case (cmd.cal_sel)
                2'd0: begin mem_wa = fr1; mem_wd = 32'd0; end
                2'd1: begin mem_wa = fr2; mem_wd = cur_reg; end
                2'd2: begin mem_wa = fr3; mem_wd = bp_reg; end
                2'd3:
                begin
                    mem_wa  = fr4;
                    mem_wd  = 32'(pc_reg);
                    bp_next = fr1;
                    pc_next = set_pc(m_reg);
                end
                default: ;
            endcase
        end

        if (cmd.rtn_issue_a)
        begin
            mem_re = 1'b1;
            mem_ra = ret_a;
        end

        if (cmd.rtn_issue_b)
        begin
            mem_re   = 1'b1;
            mem_ra   = ret_b;
            tmp_next = mem_rd;
        end

        if (cmd.rtn_finish)
        begin
            sp_next = ret_base;
            bp_next = tmp_reg;
            pc_next = set_pc(mem_rd);
        end

        if (cmd.div_finish)
        begin
            wr_en   = 1'b1;
            wr_data = (op_t'(op_reg) == OP_DIV) ? div_q : div_r;
        end

        if (cmd.clr_wr)
        begin
            mem_we   = 1'b1;
            mem_wa   = 32'(clr_reg);
            mem_wd   = 32'd0;
            clr_next = clr_reg + SA_W'(1);
        end

        if (cmd.finish)
        begin
            full_next   = 1'b1;
            opc_next    = 10'(pc_reg);
            oemit_next  = emit_reg;
            oval_next   = ov_reg;
            ohalt_next  = !running_reg || (pc_reg == CL_PC);
            ofault_next = fault_reg;
            if (pc_reg == CL_PC)
            begin
                running_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            bp_reg      <= 32'd1;
            sp_reg      <= 32'd0;
            running_reg <= 1'b1;
            clr_reg     <= '0;
            full_reg    <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= 32'd0;
            end
        end
        else
        begin
            pc_reg      <= pc_next;
            bp_reg      <= bp_next;
            sp_reg      <= sp_next;
            running_reg <= running_next;
            clr_reg     <= clr_next;
            full_reg    <= full_next;
            if (wr_en && reg_ok({29'd0, r_reg}))
            begin
                regs_reg[r_reg[RI_W-1:0]] <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        r_reg      <= r_next;
        l_reg      <= l_next;
        m_reg      <= m_next;
        rv_reg     <= rv_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        cur_reg    <= cur_next;
        lvl_reg    <= lvl_next;
        tmp_reg    <= tmp_next;
        fault_reg  <= fault_next;
        emit_reg   <= emit_next;
        ov_reg     <= ov_next;
        opc_reg    <= opc_next;
        oemit_reg  <= oemit_next;
        oval_reg   <= oval_next;
        ohalt_reg  <= ohalt_next;
        ofault_reg <= ofault_next;
    end

    rsvm_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wa[SA_W-1:0]),
        .wdata (mem_wd),
        .re    (mem_re),
        .raddr (mem_ra[SA_W-1:0]),
        .rdata (mem_rd)
    );

    rsvm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (x_reg),
        .divisor   (y_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        sts.clear_last = (clr_reg == CLR_LAST);
        sts.running    = running_reg;
        sts.opcode     = op_reg;
        sts.walk_bad   = 32'(l_reg) > 32'(MAX_LEVELS);
        sts.walk_zero  = (lvl_reg == 3'd0);
        sts.link_ok    = in_stack(link_addr);
        sts.addr_ok    = in_stack(data_addr);
        sts.frame_ok   = in_stack(fr1) && in_stack(fr2) && in_stack(fr3) && in_stack(fr4);
        sts.ret_ok     = in_stack(ret_a) && in_stack(ret_b);
        sts.y_zero     = (y_reg == 32'sd0);
        sts.div_done   = div_done;
        sts.slot_free  = slot_free;
    end

    assign res_valid = full_reg;
    assign next_pc   = opc_reg;
    assign out_valid = oemit_reg;
    assign out_value = oval_reg;
    assign halted    = ohalt_reg;
    assign fault     = ofault_reg;

endmodule

[rtl/rsvm_ctrl.sv]
// Controller state machine that sequences each instruction through the datapath.
module rsvm_ctrl import rsvm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    op_t    op;

    assign op = op_t'(sts.opcode);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (sts.clear_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.running ? ST_RD_Y : ST_RESULT;
                end
            end
            ST_RD_Y:      state_next = ST_RD_Z;
            ST_RD_Z:      state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                case (op)
                    OP_LOD, OP_STO, OP_CAL:
                        state_next = sts.walk_bad ? ST_RESULT : ST_WALK;
                    OP_RTN:
                        state_next = ST_RTN_RD;
                    OP_DIV, OP_MOD:
                        state_next = sts.y_zero ? ST_RESULT : ST_DIV;
                    default:
                        state_next = ST_RESULT;
                endcase
            end
            ST_WALK:
            begin
                if (!sts.walk_zero)
                begin
                    state_next = sts.link_ok ? ST_WALK_WAIT : ST_RESULT;
                end
                else if (op == OP_CAL)
                begin
                    state_next = sts.frame_ok ? ST_CAL_W0 : ST_RESULT;
                end
                else if (op == OP_LOD)
                begin
                    state_next = sts.addr_ok ? ST_LOD_WAIT : ST_RESULT;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_WALK_WAIT: state_next = ST_WALK;
            ST_LOD_WAIT:  state_next = ST_RESULT;
            ST_CAL_W0:    state_next = ST_CAL_W1;
            ST_CAL_W1:    state_next = ST_CAL_W2;
            ST_CAL_W2:    state_next = ST_CAL_W3;
            ST_CAL_W3:    state_next = ST_RESULT;
            ST_RTN_RD:    state_next = sts.ret_ok ? ST_RTN_W0 : ST_RESULT;
            ST_RTN_W0:    state_next = ST_RTN_W1;
            ST_RTN_W1:    state_next = ST_RESULT;
            ST_DIV:       if (sts.div_done) state_next = ST_RESULT;
            ST_RESULT:    if (sts.slot_free) state_next = ST_IDLE;
            default:      state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:     cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_RD_Y:      cmd.rd_y = 1'b1;
            ST_RD_Z:      cmd.rd_z = 1'b1;
            ST_DISPATCH:
            begin
                case (op)
                    OP_LOD, OP_STO, OP_CAL:
                    begin
                        cmd.walk_init  = 1'b1;
                        cmd.fail_range = sts.walk_bad;
                    end
                    OP_RTN: ;
                    OP_DIV, OP_MOD:
                    begin
                        cmd.exec      = sts.y_zero;
                        cmd.div_start = !sts.y_zero;
                    end
                    default: cmd.exec = 1'b1;
                endcase
            end
            ST_WALK:
            begin
                if (!sts.walk_zero)
                begin
                    cmd.walk_issue = sts.link_ok;
                    cmd.fail_range = !sts.link_ok;
                end
                else if (op == OP_CAL)
                begin
                    cmd.fail_range = !sts.frame_ok;
                end
                else if (op == OP_LOD)
                begin
                    cmd.lod_issue  = sts.addr_ok;
                    cmd.fail_range = !sts.addr_ok;
                end
                else
                begin
                    cmd.sto_write  = sts.addr_ok;
                    cmd.fail_range = !sts.addr_ok;
                end
            end
            ST_WALK_WAIT: cmd.walk_step = 1'b1;
            ST_LOD_WAIT:  cmd.lod_write = 1'b1;
            ST_CAL_W0:    begin cmd.cal_wr = 1'b1; cmd.cal_sel = 2'd0; end
            ST_CAL_W1:    begin cmd.cal_wr = 1'b1; cmd.cal_sel = 2'd1; end
            ST_CAL_W2:    begin cmd.cal_wr = 1'b1; cmd.cal_sel = 2'd2; end
            ST_CAL_W3:    begin cmd.cal_wr = 1'b1; cmd.cal_sel = 2'd3; end
            ST_RTN_RD:
            begin
                cmd.rtn_issue_a = sts.ret_ok;
                cmd.fail_range  = !sts.ret_ok;
            end
            ST_RTN_W0:    cmd.rtn_issue_b = 1'b1;
            ST_RTN_W1:    cmd.rtn_finish = 1'b1;
            ST_DIV:       cmd.div_finish = sts.div_done;
            ST_RESULT:    cmd.finish = sts.slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/register_stack_vm_execute.sv]
// Each request is taken in the idle state, reads its Y and Z operands, is dispatched
// and ends in the result state; a request to a halted machine goes from idle straight
// to the result state. Static-link walks, load/store, call, return and divide/mod
// add states of their own. The controller takes one request at a time, and the next
// only once the previous result has gone into the output register. After reset a
// clearing pass zeroes the frame memory; no request is accepted until it ends.
module register_stack_vm_execute import rsvm_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int CODE_LENGTH = CODE_LENGTH_DEF,
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
    parameter int NUM_REGS    = NUM_REGS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    rsvm_in_if.sink    instr,
    rsvm_out_if.source result
);

    // The controller and datapath talk only through these two bundles.
    cmd_t cmd;
    sts_t sts;

    // The controller owns the request handshake; a request is taken only in its
    // idle state, while a finished result may still sit in the output register.
    rsvm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (instr.valid),
        .in_ready (instr.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds all architectural state and the result register that
    // drives the result channel.
    rsvm_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .CODE_LENGTH (CODE_LENGTH),
        .MAX_LEVELS  (MAX_LEVELS),
        .NUM_REGS    (NUM_REGS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (instr.opcode),
        .reg_index    (instr.reg_index),
        .level_or_reg (instr.level_or_reg),
        .modifier     (instr.modifier),
        .read_value   (instr.read_value),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .next_pc      (result.next_pc),
        .out_valid    (result.out_valid),
        .out_value    (result.out_value),
        .halted       (result.halted),
        .fault        (result.fault)
    );

endmodule

[rtl/rsvm_checker.sv]
// Port-level checker for the result channel, bound to the top level.
module rsvm_checker import rsvm_pkg::*; #(
    parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [9:0]  next_pc,
    input logic        out_valid,
    input logic [1:0]  fault,
    input logic        halted
);

    logic seen_halt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
        end
        else if (res_valid && res_ready && halted)
        begin
            seen_halt_reg <= 1'b1;
        end
    end

    // A stalled result stays valid and keeps its next_pc and fault.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(next_pc) && $stable(fault))
        else $error("result changed while stalled");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> fault != 2'd3)
        else $error("undefined fault code");

    // An emitted value never comes with a fault; the emitting step may still
    // be the one that runs the counter into the code end.
    a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> fault == 2'(FAULT_NONE))
        else $error("emitted value with fault");

    // Once the machine has stopped it stays stopped until reset.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && seen_halt_reg |-> halted && (32'(next_pc) == 32'(CODE_LENGTH % 1024)
                                                  || fault == 2'(FAULT_NONE)))
        else $error("machine resumed after halt");

endmodule

bind register_stack_vm_execute rsvm_checker #(
    .CODE_LENGTH (CODE_LENGTH)
) u_rsvm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .next_pc   (result.next_pc),
    .out_valid (result.out_valid),
    .fault     (result.fault),
    .halted    (result.halted)
);
